@@ rtl/afp_pkg.sv @@
// Shared types, codes and helpers for the converter frame parser.
package afp_pkg;

  localparam logic [7:0] SUM_SEED   = 8'h9B;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [2:0] DATA_BYTES = 3'd4;
  localparam logic [7:0] NEW_DATA_BIT = 8'h40;

  // register indexes on the APB port
  localparam logic [1:0] REG_INTERFACE_KNOWN = 2'd0;
  localparam logic [1:0] REG_STATUS_BYTE_ON  = 2'd1;
  localparam logic [1:0] REG_INTEGRITY_MODE  = 2'd2;
  localparam logic [1:0] REG_FAULT_MASK      = 2'd3;

  // integrity trailer kinds
  localparam logic [1:0] INTEG_NONE = 2'd0;
  localparam logic [1:0] INTEG_SUM  = 2'd1;

  typedef enum logic [2:0] {
    OC_OK         = 3'd0,
    OC_NOT_CONFIG = 3'd1,
    OC_MISMATCH   = 3'd2,
    OC_FAULT      = 3'd3,
    OC_NO_DATA    = 3'd4
  } outcome_t;

  typedef struct packed {
    logic       interface_known;
    logic       status_byte_on;
    logic [1:0] integrity_mode;
    logic [7:0] fault_mask;
  } cfg_t;

  typedef struct packed {
    outcome_t          outcome;
    logic              saturated;
    logic [7:0]        status_raw;
    logic signed [31:0] conversion_code;
  } res_t;

  // CRC-8, polynomial 0x07, one byte, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/afp_apb_regs.sv @@
// APB configuration registers of the frame parser.
module afp_apb_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output afp_pkg::cfg_t cfg
);
  import afp_pkg::*;

  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interface_known <= 1'b0;
      cfg.status_byte_on  <= 1'b1;
      cfg.integrity_mode  <= INTEG_SUM;
      cfg.fault_mask      <= 8'd30;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_INTERFACE_KNOWN: cfg.interface_known <= pwdata[0];
        REG_STATUS_BYTE_ON:  cfg.status_byte_on  <= pwdata[0];
        REG_INTEGRITY_MODE:  cfg.integrity_mode  <= pwdata[1:0];
        REG_FAULT_MASK:      cfg.fault_mask      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INTERFACE_KNOWN: prdata = {31'd0, cfg.interface_known};
      REG_STATUS_BYTE_ON:  prdata = {31'd0, cfg.status_byte_on};
      REG_INTEGRITY_MODE:  prdata = {30'd0, cfg.integrity_mode};
      REG_FAULT_MASK:      prdata = {24'd0, cfg.fault_mask};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/afp_parser.sv @@
// Frame state and per-byte parse step: accumulators, integrity check, outcome.
module afp_parser (
  input  logic          clk,
  input  logic          rst,
  input  afp_pkg::cfg_t cfg,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  input  logic          frame_start,
  output logic          res_valid,
  output afp_pkg::res_t res
);
  import afp_pkg::*;

  logic [2:0]  pos, pos_next;
  logic        disc, disc_next;
  logic [7:0]  stat, stat_next;
  logic [31:0] shift, shift_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  crc, crc_next;

  logic        first;
  logic [2:0]  base_pos;
  logic [7:0]  base_stat;
  logic [31:0] base_shift;
  logic [7:0]  base_sum;
  logic [7:0]  base_crc;
  logic [2:0]  data_idx;
  logic        is_end;
  logic        mismatch;
  logic        integ;
  logic [7:0]  chk_byte;
  logic [7:0]  stat_out;
  logic        sat;

  assign first = frame_start || (pos == 3'd0 && !disc);
  assign integ = cfg.integrity_mode != INTEG_NONE;

  always_comb begin
    pos_next   = pos;
    disc_next  = disc;
    stat_next  = stat;
    shift_next = shift;
    sum_next   = sum;
    crc_next   = crc;
    res_valid  = 1'b0;
    res        = '0;
    res.outcome = OC_OK;
    is_end     = 1'b0;
    mismatch   = 1'b0;
    chk_byte   = 8'd0;
    stat_out   = 8'd0;
    sat        = 1'b0;

    // a first byte sees cleared frame state
    base_pos   = first ? 3'd0  : pos;
    base_stat  = first ? 8'd0  : stat;
    base_shift = first ? 32'd0 : shift;
    base_sum   = first ? SUM_SEED : sum;
    base_crc   = first ? 8'd0  : crc;
    data_idx   = base_pos - {2'd0, cfg.status_byte_on};

    if (!first && disc) begin
      // drop bytes until the next frame start
    end else if (first && !cfg.interface_known) begin
      pos_next    = 3'd0;
      disc_next   = 1'b1;
      stat_next   = 8'd0;
      shift_next  = 32'd0;
      sum_next    = SUM_SEED;
      crc_next    = 8'd0;
      res_valid   = 1'b1;
      res.outcome = OC_NOT_CONFIG;
    end else begin
      pos_next   = base_pos;
      disc_next  = 1'b0;
      stat_next  = base_stat;
      shift_next = base_shift;
      sum_next   = base_sum;
      crc_next   = base_crc;
      if (cfg.status_byte_on && base_pos == 3'd0) begin
        stat_next = rx_byte;
      end else if (data_idx < DATA_BYTES) begin
        shift_next = {base_shift[23:0], rx_byte};
        sum_next   = base_sum + rx_byte;
        crc_next   = crc8_update(base_crc, rx_byte);
        is_end     = (data_idx == DATA_BYTES - 3'd1) && !integ;
      end else begin
        is_end   = 1'b1;
        chk_byte = (cfg.integrity_mode == INTEG_SUM) ? base_sum : base_crc;
        mismatch = integ && (rx_byte != chk_byte);
      end

      stat_out = cfg.status_byte_on ? stat_next : 8'd0;
      sat      = (shift_next == 32'h7FFF_FFFF) || (shift_next == 32'h8000_0000);

      if (is_end) begin
        pos_next       = 3'd0;
        disc_next      = 1'b1;
        res_valid      = 1'b1;
        res.status_raw = stat_out;
        if (mismatch) begin
          res.outcome = OC_MISMATCH;
        end else begin
          res.conversion_code = shift_next;
          res.saturated       = sat;
          priority if (cfg.status_byte_on && (stat_next & cfg.fault_mask) != 8'd0) begin
            res.outcome = OC_FAULT;
          end else if (cfg.status_byte_on && (stat_next & NEW_DATA_BIT) == 8'd0) begin
            res.outcome = OC_NO_DATA;
          end else if (sat) begin
            res.outcome = OC_FAULT;
          end else begin
            res.outcome = OC_OK;
          end
        end
      end else begin
        pos_next = base_pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= 3'd0;
      disc  <= 1'b0;
      stat  <= 8'd0;
      shift <= 32'd0;
      sum   <= SUM_SEED;
      crc   <= 8'd0;
    end else if (step) begin
      pos   <= pos_next;
      disc  <= disc_next;
      stat  <= stat_next;
      shift <= shift_next;
      sum   <= sum_next;
      crc   <= crc_next;
    end
  end

endmodule

@@ rtl/adc_conversion_frame_parser_unit.sv @@
// Top level of the converter frame parser: input register, parse step, result register.
// A held byte is parsed and its result registered while the output is not stalled.
// Throughput: one byte per cycle without output stalls, limited by the single parse step.
// A result stalled at the output holds one byte in the input register, then s_tready drops.
// Reset (rst, synchronous) clears the frame state, the stream valids and the registers
// to their defaults: not configured, status byte on, additive checksum, fault mask 0x1E.
module adc_conversion_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] conversion_code, [39:32] status_raw
  output logic [3:0]  m_tuser,   // [0] saturated, [3:1] outcome
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import afp_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  afp_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (advance),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  // advance the held request when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.status_raw, out_res.conversion_code};
  assign m_tuser = {out_res.outcome, out_res.saturated};

endmodule

@@ test/tb_top.sv @@
// Self-checking stream testbench for the converter frame parser with a scoreboard class.
module tb_top;
  import afp_pkg::*;

  localparam logic [1:0] INTEG_CRC     = 2'd2;
  localparam logic [1:0] INTEG_CRC_ALT = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;

  class frame_scoreboard;
    cfg_t        regs;
    logic [2:0]  pos;
    bit          drop_rest;
    logic [7:0]  stat;
    logic [31:0] shift;
    logic [7:0]  sum;
    logic [7:0]  crc;
    res_t        results_due[$];
    int          errors;
    int          checked;

    function new();
      regs.interface_known = 1'b0;
      regs.status_byte_on  = 1'b1;
      regs.integrity_mode  = INTEG_SUM;
      regs.fault_mask      = 8'h1E;
      pos       = '0;
      drop_rest = 1'b0;
      stat      = '0;
      shift     = '0;
      sum       = SUM_SEED;
      crc       = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    static function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
      logic [7:0] x;
      x = c ^ b;
      repeat (8) x = x[7] ? ({x[6:0], 1'b0} ^ CRC_POLY) : {x[6:0], 1'b0};
      return x;
    endfunction

    function void queue_result(logic [31:0] code, logic [7:0] st, logic sat, outcome_t oc);
      res_t r;
      r.conversion_code = code;
      r.status_raw      = st;
      r.saturated       = sat;
      r.outcome         = oc;
      results_due.push_back(r);
    endfunction

    // Advance the frame state by one accepted request.
    function void parse_byte(logic [7:0] b, logic first_flag);
      bit         s;
      bit         end_hit;
      bit         sat;
      logic [2:0] p;
      int         d;
      logic [7:0] want;
      outcome_t   oc;
      s = regs.status_byte_on;
      end_hit = 1'b0;
      if (first_flag || (pos == 3'd0 && !drop_rest)) begin
        pos = '0;
        drop_rest = 1'b0;
        stat = '0;
        shift = '0;
        sum = SUM_SEED;
        crc = '0;
        if (!regs.interface_known) begin
          drop_rest = 1'b1;
          queue_result(32'd0, 8'd0, 1'b0, OC_NOT_CONFIG);
          return;
        end
      end else if (drop_rest) begin
        return;
      end
      p = pos;
      if (s && p == 3'd0) begin
        stat = b;
      end else begin
        d = int'(p) - int'(s);
        if (d < int'(DATA_BYTES)) begin
          shift = {shift[23:0], b};
          sum = sum + b;
          crc = crc_step(crc, b);
          if (d == int'(DATA_BYTES) - 1 && regs.integrity_mode == INTEG_NONE) end_hit = 1'b1;
        end else begin
          end_hit = 1'b1;
          if (regs.integrity_mode != INTEG_NONE) begin
            want = (regs.integrity_mode == INTEG_SUM) ? sum : crc;
            if (b != want) begin
              pos = '0;
              drop_rest = 1'b1;
              queue_result(32'd0, s ? stat : 8'd0, 1'b0, OC_MISMATCH);
              return;
            end
          end
        end
      end
      if (!end_hit) begin
        pos = p + 3'd1;
        return;
      end
      pos = '0;
      drop_rest = 1'b1;
      sat = (shift == 32'h7FFF_FFFF) || (shift == 32'h8000_0000);
      if (s && (stat & regs.fault_mask) != 8'd0) oc = OC_FAULT;
      else if (s && (stat & NEW_DATA_BIT) == 8'd0) oc = OC_NO_DATA;
      else if (sat) oc = OC_FAULT;
      else oc = OC_OK;
      queue_result(shift, s ? stat : 8'd0, sat, oc);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task compare_frame_result(logic [39:0] tdata, logic [3:0] tuser);
      res_t w;
      if (results_due.size() == 0) begin
        report($sformatf("result %h/%h with nothing pending", tdata, tuser));
        return;
      end
      w = results_due.pop_front();
      checked++;
      if (tdata[31:0] !== w.conversion_code)
        report($sformatf("conversion_code %h, want %h", tdata[31:0], w.conversion_code));
      if (tdata[39:32] !== w.status_raw)
        report($sformatf("status_raw %h, want %h", tdata[39:32], w.status_raw));
      if (tuser[0] !== w.saturated)
        report($sformatf("saturated %b, want %b", tuser[0], w.saturated));
      if (tuser[3:1] !== w.outcome)
        report($sformatf("outcome %0d, want %s", tuser[3:1], w.outcome.name()));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] rx_byte
  logic [0:0]  s_tuser = 1'b0;   // [0] frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [31:0] conversion_code, [39:32] status_raw
  logic [3:0]  m_tuser;          // [0] saturated, [3:1] outcome
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb = new();

  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  int stall_left = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_applied = 0;

  adc_conversion_frame_parser_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left = pick_gap() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.compare_frame_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               sb.results_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] trailer_for(logic [31:0] code, logic [1:0] mode);
    logic [7:0] s;
    logic [7:0] c;
    s = SUM_SEED;
    c = 8'd0;
    for (int i = 3; i >= 0; i--) begin
      s = s + code[8*i +: 8];
      c = frame_scoreboard::crc_step(c, code[8*i +: 8]);
    end
    return (mode == INTEG_SUM) ? s : c;
  endfunction

  function automatic logic [7:0] pick_status(logic [7:0] mask);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1: return (r & ~mask) | NEW_DATA_BIT;
      2: return r;
      default: return r & ~mask & ~NEW_DATA_BIT;
    endcase
  endfunction

  function automatic logic [31:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= st;
    do @(posedge clk); while (!s_tready);
    sb.parse_byte(b, st);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Lay out one frame for the current register settings.
  task automatic send_frame(input logic [7:0] st, input logic [31:0] code, input bit bad_trailer);
    logic [7:0] chk;
    bit         first;
    first = 1'b1;
    if (sb.regs.status_byte_on) begin
      send_byte(st, 1'b1);
      first = 1'b0;
    end
    for (int i = 3; i >= 0; i--) begin
      send_byte(code[8*i +: 8], first);
      first = 1'b0;
    end
    if (sb.regs.integrity_mode != INTEG_NONE) begin
      chk = trailer_for(code, sb.regs.integrity_mode);
      if (bad_trailer) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(chk, 1'b0);
    end
    frames_sent++;
  endtask

  // Hold the sender until every pending result is out, then let the pipe empty.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_INTERFACE_KNOWN: sb.regs.interface_known = val[0];
      REG_STATUS_BYTE_ON:  sb.regs.status_byte_on  = val[0];
      REG_INTEGRITY_MODE:  sb.regs.integrity_mode  = val[1:0];
      REG_FAULT_MASK:      sb.regs.fault_mask      = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) sb.report($sformatf("register %0d reads %h, want %h", idx, prdata, val));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_registers(input logic known, input logic st_on, input logic [1:0] mode,
                               input logic [7:0] mask);
    drain_pipeline();
    apb_write_reg(REG_INTERFACE_KNOWN, {31'd0, known});
    apb_write_reg(REG_STATUS_BYTE_ON, {31'd0, st_on});
    apb_write_reg(REG_INTEGRITY_MODE, {30'd0, mode});
    apb_write_reg(REG_FAULT_MASK, {24'd0, mask});
    settings_applied++;
  endtask

  task automatic run_random_phase(input int target);
    int  start_count;
    int  k;
    int  n;
    bit  paused;
    start_count = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start_count < target) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        send_frame(pick_status(sb.regs.fault_mask), pick_code(), $urandom_range(0, 6) == 0);
      end else if (k < 90) begin
        // truncated frame, dropped by the next frame_start
        n = $urandom_range(0, 3);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      end
      if (!paused && bytes_sent - start_count >= target / 2) begin
        drain_pipeline();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Not configured: first byte after reset without frame_start, then an ignored byte.
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    set_registers(1'b1, 1'b1, INTEG_SUM, 8'h1E);
    send_frame(8'h40, 32'h7FFF_FFFF, 1'b0);
    send_frame(8'hFF, 32'h8000_0000, 1'b1);
    // byte after the end of a frame, ignored
    send_byte(8'hC3, 1'b0);
    // restart within a frame drops the partial one
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_frame(8'h00, 32'h0102_0304, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      src_gaps_on    = (ph % 4) != 1;
      sink_stalls_on = (ph % 4) != 2;
      case (ph)
        0: set_registers(1'b1, 1'b1, INTEG_SUM, 8'h00);
        1: set_registers(1'b1, 1'b0, INTEG_NONE, 8'hFF);
        2: set_registers(1'b1, 1'b1, INTEG_CRC, 8'hFF);
        3: set_registers(1'b1, 1'b0, INTEG_CRC_ALT, 8'h1E);
        4: set_registers(1'b0, 1'b1, INTEG_SUM, 8'($urandom_range(0, 255)));
        default: set_registers($urandom_range(0, 5) != 0, 1'($urandom_range(0, 1)),
                               2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      endcase
      run_random_phase(ph == 4 ? 30 : 125);
    end

    drain_pipeline();
    $display("Sent %0d bytes in %0d frames over %0d register settings.", bytes_sent,
             frames_sent, settings_applied);
    $display("Compared %0d frame results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
